FILE: rtl/tap_to_tzx_stream_converter_defines.svh
// Assertion macros used by the tape converter emitter RTL.
`ifndef TAP_TO_TZX_STREAM_CONVERTER_DEFINES_SVH
`define TAP_TO_TZX_STREAM_CONVERTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define TZX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tzx assertion failed");
// Next-cycle implication, checked outside reset.
`define TZX_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tzx assertion failed");
`else
`define TZX_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TZX_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/tzx_pkg.sv
// Types, constants and the signature table of the tape converter.
package tzx_pkg;

	typedef enum logic [2:0] {
		PH_START,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_PAYLOAD,
		PH_ERROR
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_HDR,
		KIND_BYTE,
		KIND_STATUS
	} kind_t;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_TRUNC_LEN = 2'd1;
	localparam status_t ST_ZERO_SIZE = 2'd2;
	localparam status_t ST_TRUNC_BLK = 2'd3;

	localparam logic [7:0]  BLOCK_ID    = 8'h10;
	localparam logic [15:0] PAUSE_RESET = 16'd1000;
	localparam logic [3:0]  SIG_LEN     = 4'd10;
	localparam logic [3:0]  HDR_LEN     = 4'd5;

	// One accepted item's worth of results: optional signature, then an optional body.
	typedef struct packed {
		logic        sig;
		kind_t       kind;
		logic [7:0]  byte_lo;
		logic [7:0]  byte_hi;
		logic [15:0] pause;
		status_t     status;
		logic        last;
	} desc_t;

	function automatic logic [7:0] sig_byte(input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0: b = 8'h5a;
			4'd1: b = 8'h58;
			4'd2: b = 8'h54;
			4'd3: b = 8'h61;
			4'd4: b = 8'h70;
			4'd5: b = 8'h65;
			4'd6: b = 8'h21;
			4'd7: b = 8'h1a;
			4'd8: b = 8'h01;
			4'd9: b = 8'h14;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

FILE: rtl/tzx_regs.sv
// APB configuration register holding the block pause.
module tzx_regs import tzx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] pause_ms
);

	logic [15:0] pause_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pause_q <= PAUSE_RESET;
		end else if (wr_en) begin
			pause_q <= pwdata[15:0];
		end
	end

	always_comb begin
		if (paddr[2] == 1'b0) begin
			prdata = {16'd0, pause_q};
		end else begin
			prdata = 32'd0;
		end
	end

	assign pause_ms = pause_q;

endmodule

FILE: rtl/tzx_parse.sv
// Source image parser: tracks block framing and issues result descriptors.
module tzx_parse import tzx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [7:0]  data_byte,
	input  logic        is_end,
	input  logic [15:0] pause_ms,
	input  logic        slot_free,
	output desc_t       desc,
	output logic        desc_load
);

	phase_t      phase_q, phase_d, eff_phase;
	logic [7:0]  len_lo_q, len_lo_d;
	logic [15:0] rem_q, rem_d, rem_dec, size;
	status_t     err_q, err_d;
	logic        accept;

	assign accept    = in_valid && slot_free;
	assign eff_phase = (phase_q == PH_START) ? PH_LEN_LO : phase_q;
	assign size      = {data_byte, len_lo_q};
	assign rem_dec   = (rem_q != 16'd0) ? (rem_q - 16'd1) : rem_q;

	// next state
	always_comb begin
		phase_d  = phase_q;
		len_lo_d = len_lo_q;
		rem_d    = rem_q;
		err_d    = err_q;
		if (accept) begin
			phase_d = eff_phase;
			if (is_end) begin
				phase_d  = PH_START;
				len_lo_d = 8'd0;
				rem_d    = 16'd0;
				err_d    = ST_OK;
			end else begin
				case (eff_phase)
					PH_LEN_LO: begin
						len_lo_d = data_byte;
						phase_d  = PH_LEN_HI;
					end
					PH_LEN_HI: begin
						if (size == 16'd0) begin
							err_d   = ST_ZERO_SIZE;
							phase_d = PH_ERROR;
						end else begin
							rem_d   = size;
							phase_d = PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						rem_d = rem_dec;
						if (rem_dec == 16'd0) begin
							phase_d = PH_LEN_LO;
						end
					end
					default: begin
						// swallow
					end
				endcase
			end
		end
	end

	// descriptor for the results of this item
	always_comb begin
		desc         = '0;
		desc.sig     = (phase_q == PH_START);
		desc.kind    = KIND_NONE;
		desc.byte_lo = data_byte;
		desc.byte_hi = data_byte;
		desc.pause   = pause_ms;
		desc.status  = ST_OK;
		desc.last    = 1'b0;
		if (is_end) begin
			desc.kind = KIND_STATUS;
			desc.last = 1'b1;
			if (err_q != ST_OK) begin
				desc.status = err_q;
			end else if (eff_phase == PH_LEN_HI) begin
				desc.status = ST_TRUNC_LEN;
			end else if (eff_phase == PH_PAYLOAD && rem_q != 16'd0) begin
				desc.status = ST_TRUNC_BLK;
			end
		end else begin
			case (eff_phase)
				PH_LEN_HI: begin
					desc.byte_lo = len_lo_q;
					if (size == 16'd0) begin
						desc.kind   = KIND_STATUS;
						desc.status = ST_ZERO_SIZE;
					end else begin
						desc.kind = KIND_HDR;
					end
				end
				PH_PAYLOAD: desc.kind = KIND_BYTE;
				default:    desc.kind = KIND_NONE;
			endcase
		end
	end

	assign desc_load = accept && (desc.sig || desc.kind != KIND_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			len_lo_q <= 8'd0;
			rem_q    <= 16'd0;
			err_q    <= ST_OK;
		end else begin
			phase_q  <= phase_d;
			len_lo_q <= len_lo_d;
			rem_q    <= rem_d;
			err_q    <= err_d;
		end
	end

endmodule

FILE: rtl/tzx_emit.sv
// Result emitter: walks one descriptor into output results, one per cycle while the output does not stall.
`include "tap_to_tzx_stream_converter_defines.svh"
module tzx_emit import tzx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  desc_t      desc,
	input  logic       desc_load,
	output logic       slot_free,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output status_t    status,
	output logic       last_result
);

	desc_t      desc_s1;
	logic       desc_valid_s1;
	logic [3:0] idx_q, count, body_len, body_idx;
	logic       emit, last_idx;
	logic [7:0] r_byte;
	logic       r_valid, r_last;
	status_t    r_status;

	logic       out_valid_q, byte_valid_q, last_q;
	logic [7:0] byte_q;
	status_t    status_q;

	always_comb begin
		case (desc_s1.kind)
			KIND_HDR:    body_len = HDR_LEN;
			KIND_BYTE:   body_len = 4'd1;
			KIND_STATUS: body_len = 4'd1;
			default:     body_len = 4'd0;
		endcase
	end

	assign count     = (desc_s1.sig ? SIG_LEN : 4'd0) + body_len;
	assign body_idx  = idx_q - (desc_s1.sig ? SIG_LEN : 4'd0);
	assign emit      = desc_valid_s1 && (!out_valid_q || !out_stall);
	assign last_idx  = (idx_q == count - 4'd1);
	assign slot_free = !desc_valid_s1 || (emit && last_idx);

	// select the result at the current index
	always_comb begin
		r_byte   = 8'd0;
		r_valid  = 1'b1;
		r_status = ST_OK;
		r_last   = 1'b0;
		if (desc_s1.sig && idx_q < SIG_LEN) begin
			r_byte = sig_byte(idx_q);
		end else begin
			case (desc_s1.kind)
				KIND_HDR: begin
					case (body_idx)
						4'd0:    r_byte = BLOCK_ID;
						4'd1:    r_byte = desc_s1.pause[7:0];
						4'd2:    r_byte = desc_s1.pause[15:8];
						4'd3:    r_byte = desc_s1.byte_lo;
						4'd4:    r_byte = desc_s1.byte_hi;
						default: r_byte = 8'd0;
					endcase
				end
				KIND_BYTE: r_byte = desc_s1.byte_lo;
				KIND_STATUS: begin
					r_valid  = 1'b0;
					r_status = desc_s1.status;
					r_last   = desc_s1.last;
				end
				default: r_valid = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_valid_s1 <= 1'b0;
			idx_q         <= 4'd0;
			out_valid_q   <= 1'b0;
		end else begin
			if (desc_load) begin
				desc_valid_s1 <= 1'b1;
				idx_q         <= 4'd0;
			end else if (emit) begin
				if (last_idx) begin
					desc_valid_s1 <= 1'b0;
					idx_q         <= 4'd0;
				end else begin
					idx_q <= idx_q + 4'd1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (desc_load) begin
			desc_s1 <= desc;
		end
		if (emit) begin
			byte_q       <= r_byte;
			byte_valid_q <= r_valid;
			status_q     <= r_status;
			last_q       <= r_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = byte_q;
	assign byte_valid  = byte_valid_q;
	assign status      = status_q;
	assign last_result = last_q;

	`TZX_ASSERT_IMP(a_idx_in_range, clk, arst_n, desc_valid_s1, idx_q < count)
	`TZX_ASSERT_IMP(a_stall_only_busy, clk, arst_n, !slot_free, desc_valid_s1)
	`TZX_ASSERT_IMP(a_byte_has_no_status, clk, arst_n, out_valid_q && byte_valid_q,
		status_q == ST_OK && !last_q)
	`TZX_ASSERT_NXT(a_slot_drains, clk, arst_n, emit && last_idx && !desc_load,
		!desc_valid_s1 && idx_q == 4'd0)

endmodule

FILE: rtl/tap_to_tzx_stream_converter.sv
// Top level of the tape image to tagged-block image converter.
// Takes the source image one byte per request and emits the converted image one
// result per cycle while the output does not stall; payload then streams at one
// byte per clock. An item that opens a block header holds the input while the
// header bytes leave, and the first item of an image holds it while the
// signature (and, for an end marker, its status) leaves, because the emitter
// puts out one result per cycle from a single descriptor slot. A low length
// byte that does not open an image, and bytes swallowed after an error, produce
// no result and do not occupy the slot. A result passes through the descriptor
// slot and then the output register before it is presented at the output.
// The pause register sits at byte address 0 and is sampled when a header
// item is accepted.
module tap_to_tzx_stream_converter import tzx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        is_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic [1:0]  status,
	output logic        last_result
);

	logic [15:0] pause_ms;
	desc_t       desc;
	logic        desc_load;
	logic        slot_free;

	assign in_stall = !slot_free;

	tzx_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.pause_ms (pause_ms)
	);

	tzx_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.data_byte (data_byte),
		.is_end    (is_end),
		.pause_ms  (pause_ms),
		.slot_free (slot_free),
		.desc      (desc),
		.desc_load (desc_load)
	);

	tzx_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.desc        (desc),
		.desc_load   (desc_load),
		.slot_free   (slot_free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.status      (status),
		.last_result (last_result)
	);

endmodule

FILE: test/tb_tap_to_tzx_stream_converter.sv
// Self-checking testbench for the tape image to tagged-block image converter.
module tb_tap_to_tzx_stream_converter import tzx_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PRINT_CAP = 50;
	localparam logic [2:0] PAUSE_ADDR = 3'd0;
	localparam logic [2:0] SPARE_ADDR = 3'd4;
	localparam logic [79:0] TAPE_SIG = {"ZXTape!", 8'h1a, 8'h01, 8'h14};
	localparam int N_DIR = 23;

	typedef struct packed {
		logic [7:0] b;
		logic       v;
		status_t    st;
		logic       last;
	} conv_res_t;

	typedef struct packed {
		logic [7:0] d;
		logic       e;
		logic       chk;
		status_t    st;
		logic       last;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        is_end;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic [1:0]  status;
	logic        last_result;

	tap_to_tzx_stream_converter uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.is_end(is_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.status(status),
		.last_result(last_result)
	);

	// Converter state as the checker sees it
	phase_t      conv_phase;
	logic [7:0]  len_lo;
	logic [15:0] owed;
	status_t     err_code;
	logic [15:0] pause_now;

	conv_res_t   tzx_out_due[$];
	dir_row_t    dir_tab[N_DIR];
	int          n_errs;
	int          cycles;
	int          fed_items;
	int          stall_left;
	logic        in_gaps_on;
	logic        out_stalls_on;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic note_mismatch(input string what, input int got, input int want);
		n_errs++;
		if (n_errs <= PRINT_CAP)
			$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
	endtask

	function automatic void push_res(input logic [7:0] b, input logic v, input status_t st,
			input logic last);
		conv_res_t r;
		r.b = b;
		r.v = v;
		r.st = st;
		r.last = last;
		tzx_out_due.insert(tzx_out_due.size(), r);
	endfunction

	function automatic void clear_conv();
		conv_phase = PH_START;
		len_lo = 8'h00;
		owed = 16'h0000;
		err_code = ST_OK;
	endfunction

	// Work out the results of one accepted request.
	function automatic void tzx_convert_step(input logic [7:0] d, input logic e);
		logic [15:0] size;
		status_t st;
		if (conv_phase != PH_ERROR || e)
			fed_items++;
		if (conv_phase == PH_START) begin
			for (int i = 0; i < 10; i++)
				push_res(TAPE_SIG[79 - 8 * i -: 8], 1'b1, ST_OK, 1'b0);
			conv_phase = PH_LEN_LO;
		end
		if (e) begin
			st = err_code;
			if (st == ST_OK) begin
				if (conv_phase == PH_LEN_HI)
					st = ST_TRUNC_LEN;
				else if (conv_phase == PH_PAYLOAD && owed != 16'h0000)
					st = ST_TRUNC_BLK;
			end
			push_res(8'h00, 1'b0, st, 1'b1);
			clear_conv();
			return;
		end
		case (conv_phase)
			PH_LEN_LO: begin
				len_lo = d;
				conv_phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				size = {d, len_lo};
				if (size == 16'h0000) begin
					err_code = ST_ZERO_SIZE;
					conv_phase = PH_ERROR;
					push_res(8'h00, 1'b0, ST_ZERO_SIZE, 1'b0);
				end else begin
					push_res(BLOCK_ID, 1'b1, ST_OK, 1'b0);
					push_res(pause_now[7:0], 1'b1, ST_OK, 1'b0);
					push_res(pause_now[15:8], 1'b1, ST_OK, 1'b0);
					push_res(size[7:0], 1'b1, ST_OK, 1'b0);
					push_res(size[15:8], 1'b1, ST_OK, 1'b0);
					owed = size;
					conv_phase = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				push_res(d, 1'b1, ST_OK, 1'b0);
				if (owed != 16'h0000)
					owed--;
				if (owed == 16'h0000)
					conv_phase = PH_LEN_LO;
			end
			default: begin
				// swallow until the end marker
			end
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	task automatic send_req(input logic [7:0] d, input logic e);
		int gap;
		gap = in_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		data_byte = d;
		is_end = e;
		do @(posedge clk); while (in_stall);
		tzx_convert_step(d, e);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_valid = 1'b0;
		while (tzx_out_due.size() != 0)
			@(negedge clk);
		// length and swallowed bytes leave nothing to wait on
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == PAUSE_ADDR)
			pause_now = val[15:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic apb_check_pause();
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = PAUSE_ADDR;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== pause_now)
			note_mismatch("pause readback", prdata[15:0], pause_now);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// One source image: mostly well-formed blocks, some cut short, some noise.
	task automatic send_image();
		int nblk;
		int len;
		int npay;
		int r;
		logic cut;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			repeat ($urandom_range(0, 10)) send_req(8'($urandom), 1'b0);
		end else if (r < 10) begin
			send_req(8'($urandom), 1'b0);
		end else begin
			nblk = $urandom_range(0, 4);
			for (int k = 0; k < nblk; k++) begin
				r = $urandom_range(0, 99);
				if (r < 5)
					len = 0;
				else if (r < 12)
					len = $urandom_range(0, 65535);
				else if (r < 22)
					len = $urandom_range(13, 60);
				else
					len = $urandom_range(1, 12);
				send_req(len[7:0], 1'b0);
				send_req(len[15:8], 1'b0);
				if (len == 0) begin
					repeat ($urandom_range(0, 3)) send_req(8'($urandom), 1'b0);
					break;
				end
				cut = (len > 60) || ($urandom_range(0, 99) < 8);
				npay = cut ? $urandom_range(0, (len - 1 > 6) ? 6 : len - 1) : len;
				for (int j = 0; j < npay; j++)
					send_req(8'($urandom), 1'b0);
				if (cut)
					break;
			end
		end
		send_req(8'($urandom), 1'b1);
	endtask

	// Sink side: random stalls, mostly short, a few long
	always @(negedge clk) begin
		if (stall_left == 0 && out_stalls_on && $urandom_range(0, 99) < 20)
			stall_left = ($urandom_range(0, 99) < 8) ? $urandom_range(10, 40)
				: $urandom_range(1, 3);
		out_stall = (stall_left > 0);
		if (stall_left > 0)
			stall_left--;
	end

	always @(posedge clk) begin
		conv_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (tzx_out_due.size() == 0) begin
				note_mismatch("result with none expected", out_byte, 0);
			end else begin
				want = tzx_out_due.pop_front();
				if (out_byte !== want.b)
					note_mismatch("out_byte", out_byte, want.b);
				if (byte_valid !== want.v)
					note_mismatch("byte_valid", byte_valid, want.v);
				if (status !== want.st)
					note_mismatch("status", status, want.st);
				if (last_result !== want.last)
					note_mismatch("last_result", last_result, want.last);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_tap_to_tzx_stream_converter: done, errors");
			$finish;
		end
	end

	initial begin
		logic [31:0] cfg_val;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = PAUSE_ADDR;
		pwdata = 32'h0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		is_end = 1'b0;
		out_stall = 1'b0;
		stall_left = 0;
		in_gaps_on = 1'b0;
		out_stalls_on = 1'b0;
		n_errs = 0;
		cycles = 0;
		fed_items = 0;
		pause_now = PAUSE_RESET;
		clear_conv();

		dir_tab = '{
			'{8'h00, 1'b1, 1'b1, ST_OK, 1'b1},         // empty image
			'{8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
			'{8'h00, 1'b0, 1'b1, ST_ZERO_SIZE, 1'b0},  // zero length
			'{8'hff, 1'b0, 1'b0, ST_OK, 1'b0},         // swallowed
			'{8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
			'{8'hff, 1'b1, 1'b1, ST_ZERO_SIZE, 1'b1},
			'{8'h01, 1'b0, 1'b0, ST_OK, 1'b0},
			'{8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
			'{8'hff, 1'b0, 1'b0, ST_OK, 1'b0},
			'{8'h02, 1'b0, 1'b0, ST_OK, 1'b0},
			'{8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
			'{8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
			'{8'h00, 1'b1, 1'b1, ST_TRUNC_BLK, 1'b1},  // payload still owed
			'{8'h05, 1'b0, 1'b0, ST_OK, 1'b0},
			'{8'h7e, 1'b1, 1'b1, ST_TRUNC_LEN, 1'b1},  // only low length byte
			'{8'hff, 1'b0, 1'b0, ST_OK, 1'b0},
			'{8'hff, 1'b0, 1'b0, ST_OK, 1'b0},
			'{8'ha5, 1'b0, 1'b0, ST_OK, 1'b0},
			'{8'h00, 1'b1, 1'b1, ST_TRUNC_BLK, 1'b1},
			'{8'h01, 1'b0, 1'b0, ST_OK, 1'b0},
			'{8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
			'{8'h5a, 1'b0, 1'b0, ST_OK, 1'b0},
			'{8'h81, 1'b1, 1'b1, ST_OK, 1'b1}          // block exactly complete
		};

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		apb_check_pause();

		for (int i = 0; i < N_DIR; i++) begin
			send_req(dir_tab[i].d, dir_tab[i].e);
			if (dir_tab[i].chk)
				tzx_out_due[tzx_out_due.size() - 1] =
					'{8'h00, 1'b0, dir_tab[i].st, dir_tab[i].last};
		end

		fed_items = 0;
		for (int ph = 0; ph < 5; ph++) begin
			wait_drain();
			case (ph)
				0: cfg_val = {16'($urandom), 16'hffff};
				1: cfg_val = {16'($urandom), 16'h0000};
				3: cfg_val = 32'h0000_0001;
				default: cfg_val = $urandom;
			endcase
			apb_write(PAUSE_ADDR, cfg_val);
			if (ph == 2)
				apb_write(SPARE_ADDR, $urandom);
			apb_check_pause();
			in_gaps_on = (ph != 0);
			out_stalls_on = (ph != 1);
			while (fed_items < 80 * (ph + 1))
				send_image();
		end

		wait_drain();
		if (n_errs == 0)
			$display("tb_tap_to_tzx_stream_converter: done, clean");
		else
			$display("tb_tap_to_tzx_stream_converter: done, errors");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tzx_pkg.sv
rtl/tzx_regs.sv
rtl/tzx_parse.sv
rtl/tzx_emit.sv
rtl/tap_to_tzx_stream_converter.sv
test/tb_tap_to_tzx_stream_converter.sv
